[hw/rtl/eos_pkg.sv]
`default_nettype none

package eos_pkg;

	localparam int DATA_W        = 32;
	localparam int MAX_ITEMS_DEF = 64;

	typedef struct packed {
		logic load;       // input transaction: store value or mark drop
		logic scan_init;  // restart the search pass
		logic scan_rd;    // issue one store read
		logic advance;    // result transaction: commit the emitted entry
		logic clear;      // set done: empty the store
	} cmd_t;

	typedef struct packed {
		logic last_rd;    // current read address is the last stored entry
		logic emit_last;  // result on offer is the last one of the set
	} sts_t;

endpackage

`default_nettype wire

[hw/rtl/eos_in_if.sv]
`default_nettype none

interface eos_in_if;
	import eos_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] value;
	logic                     is_last;

	modport source (output valid, output value, output is_last, input ready);
	modport sink   (input valid, input value, input is_last, output ready);
endinterface

`default_nettype wire

[hw/rtl/eos_out_if.sv]
`default_nettype none

interface eos_out_if;
	import eos_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] sorted_value;
	logic                     final_res;
	logic                     overflow;

	modport source (output valid, output sorted_value, output final_res, output overflow,
		input ready);
	modport sink   (input valid, input sorted_value, input final_res, input overflow,
		output ready);
endinterface

`default_nettype wire

[hw/rtl/eos_ram.sv]
`default_nettype none

module eos_ram #(
	parameter int WIDTH  = 32,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [WIDTH-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/eos_datapath.sv]
`default_nettype none

module eos_datapath #(
	parameter int MAX_ITEMS = eos_pkg::MAX_ITEMS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire eos_pkg::cmd_t                    cmd,
	output eos_pkg::sts_t                         sts,
	input  wire logic signed [eos_pkg::DATA_W-1:0] value,
	output logic signed      [eos_pkg::DATA_W-1:0] sorted_value,
	output logic                                  final_res,
	output logic                                  overflow
);
	import eos_pkg::*;

	localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
	localparam int KEY_W  = DATA_W + 1;
	localparam int TUP_W  = KEY_W + ADDR_W;

	// Evens first in ascending order, then odds in descending order, as one ascending key.
	function automatic logic [KEY_W-1:0] sort_key(input logic [DATA_W-1:0] v);
		logic [DATA_W-1:0] biased;
		biased = v ^ {1'b1, {(DATA_W-1){1'b0}}};
		return v[0] ? {1'b1, ~biased} : {1'b0, biased};
	endfunction

	logic [CNT_W-1:0]  count_q;
	logic              drop_q;
	logic [CNT_W-1:0]  emit_cnt_q;
	logic [ADDR_W-1:0] rd_addr_q;
	logic              rd_vld_s1;
	logic [ADDR_W-1:0] rd_idx_s1;
	logic [DATA_W-1:0] rdata;
	logic              found_q;
	logic [TUP_W-1:0]  best_q;
	logic [DATA_W-1:0] best_val_q;
	logic              have_prev_q;
	logic [TUP_W-1:0]  prev_q;
	logic              full;
	logic [CNT_W-1:0]  last_idx;
	logic [TUP_W-1:0]  cand;
	logic              take;

	assign full     = (count_q == CNT_W'(MAX_ITEMS));
	assign last_idx = count_q - CNT_W'(1);

	eos_ram #(
		.WIDTH (DATA_W),
		.DEPTH (MAX_ITEMS),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk  (clk),
		.we   (cmd.load && !full),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(value),
		.re   (cmd.scan_rd),
		.raddr(rd_addr_q),
		.rdata(rdata)
	);

	// Pick the smallest (key, index) pair above the one emitted last.
	assign cand = {sort_key(rdata), rd_idx_s1};
	assign take = rd_vld_s1 && (!have_prev_q || cand > prev_q) && (!found_q || cand < best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			drop_q      <= 1'b0;
			emit_cnt_q  <= '0;
			rd_addr_q   <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			have_prev_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.load) begin
				if (full) begin
					drop_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
			end
			if (cmd.scan_init) begin
				rd_addr_q <= '0;
				found_q   <= 1'b0;
			end else if (cmd.scan_rd) begin
				rd_addr_q <= rd_addr_q + ADDR_W'(1);
			end
			if (take) begin
				found_q <= 1'b1;
			end
			if (cmd.advance && !cmd.clear) begin
				have_prev_q <= 1'b1;
				emit_cnt_q  <= emit_cnt_q + CNT_W'(1);
			end
			if (cmd.clear) begin
				count_q     <= '0;
				drop_q      <= 1'b0;
				emit_cnt_q  <= '0;
				have_prev_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_addr_q;
		if (take) begin
			best_q     <= cand;
			best_val_q <= rdata;
		end
		if (cmd.advance) begin
			prev_q <= best_q;
		end
	end

	assign sts.last_rd   = (CNT_W'(rd_addr_q) == last_idx);
	assign sts.emit_last = (emit_cnt_q == last_idx);

	assign sorted_value = best_val_q;
	assign final_res    = sts.emit_last;
	assign overflow     = drop_q;

endmodule

`default_nettype wire

[hw/rtl/eos_ctrl.sv]
`default_nettype none

module eos_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_last,
	output logic               in_ready,
	output logic               out_valid,
	input  wire logic          out_ready,
	output eos_pkg::cmd_t      cmd,
	input  wire eos_pkg::sts_t sts
);
	import eos_pkg::*;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_EMIT);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_LOAD: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_last) begin
						cmd.scan_init = 1'b1;
						state_d       = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (sts.last_rd) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read lands in the compare this cycle
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_ready) begin
					cmd.advance = 1'b1;
					if (sts.emit_last) begin
						cmd.clear = 1'b1;
						state_d   = ST_LOAD;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = ST_SCAN;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/even_odd_split_sorter.sv]
// Loading: one value accepted per cycle, no result until the set closes.
// Emission: each result costs one full pass over the n stored values in the
// element store, plus the result transaction. Input is held off meanwhile.
// Reset clears the controller, the element count and the drop flag; the store is not cleared.
`default_nettype none

module even_odd_split_sorter #(
	parameter int MAX_ITEMS = eos_pkg::MAX_ITEMS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	eos_in_if.sink    items,
	eos_out_if.source results
);
	import eos_pkg::*;

	cmd_t cmd;
	sts_t sts;

	eos_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_last  (items.is_last),
		.in_ready (items.ready),
		.out_valid(results.valid),
		.out_ready(results.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	eos_datapath #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.value       (items.value),
		.sorted_value(results.sorted_value),
		.final_res   (results.final_res),
		.overflow    (results.overflow)
	);

endmodule

`default_nettype wire

[test/even_odd_split_sorter_tb.sv]
`default_nettype none

module even_odd_split_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import eos_pkg::*;

	localparam int CAPACITY    = MAX_ITEMS_DEF;
	localparam int TARGET_VALS = 370;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 6000;
	localparam int TAIL_CYCLES = 200;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     final_res;
		logic                     overflow;
	} sorted_word_t;

	logic clk;
	logic arst_n;

	eos_in_if  items_if ();
	eos_out_if results_if ();

	even_odd_split_sorter #(
		.MAX_ITEMS(CAPACITY)
	) uut (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items_if),
		.results(results_if)
	);

	// Shadow of the block: values collected for the open set.
	logic signed [DATA_W-1:0] set_values [CAPACITY];
	int unsigned              set_fill;
	bit                       set_dropped;

	sorted_word_t pending_words [$];

	int  mismatches;
	int  values_loaded;
	int  values_offered;
	int  sets_closed;
	int  sets_overflowed;
	int  words_checked;
	int  quiet_cycles;
	bit  gaps_on;
	bit  hold_req;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Store the value, and on the closing item queue the sorted set: evens rising,
	// then odds falling.
	function automatic void absorb_value(logic signed [DATA_W-1:0] v, logic last);
		logic signed [DATA_W-1:0] evens [CAPACITY];
		logic signed [DATA_W-1:0] odds  [CAPACITY];
		logic signed [DATA_W-1:0] x;
		int                       n_even;
		int                       n_odd;
		int                       total;
		int                       i;
		int                       j;
		sorted_word_t             w;
		n_even = 0;
		n_odd  = 0;
		values_loaded++;
		if (set_fill < CAPACITY) begin
			set_values[set_fill] = v;
			set_fill++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!last)
			return;
		total = set_fill;
		for (i = 0; i < total; i++) begin
			x = set_values[i];
			if (x[0]) begin
				j = n_odd;
				while (j > 0 && odds[j-1] < x) begin
					odds[j] = odds[j-1];
					j--;
				end
				odds[j] = x;
				n_odd++;
			end else begin
				j = n_even;
				while (j > 0 && evens[j-1] > x) begin
					evens[j] = evens[j-1];
					j--;
				end
				evens[j] = x;
				n_even++;
			end
		end
		for (i = 0; i < total; i++) begin
			w.value     = (i < n_even) ? evens[i] : odds[i - n_even];
			w.final_res = (i == total - 1);
			w.overflow  = set_dropped;
			pending_words.push_back(w);
		end
		sets_closed++;
		if (set_dropped)
			sets_overflowed++;
		set_fill    = 0;
		set_dropped = 1'b0;
	endfunction

	function automatic void check_word(logic signed [DATA_W-1:0] v, logic fin, logic ovf);
		sorted_word_t w;
		words_checked++;
		if (pending_words.size() == 0) begin
			$error("unexpected result: sorted_value %0d final_res %0b overflow %0b", v, fin, ovf);
			mismatches++;
			return;
		end
		w = pending_words.pop_front();
		if (v !== w.value) begin
			$error("sorted_value: expected %0d, got %0d", w.value, v);
			mismatches++;
		end
		if (fin !== w.final_res) begin
			$error("final_res: expected %0b, got %0b", w.final_res, fin);
			mismatches++;
		end
		if (ovf !== w.overflow) begin
			$error("overflow: expected %0b, got %0b", w.overflow, ovf);
			mismatches++;
		end
	endfunction

	// Observe both channels; bail out when no transaction happens for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if (items_if.valid && items_if.ready)
				absorb_value(items_if.value, items_if.is_last);
			if (results_if.valid && results_if.ready)
				check_word(results_if.sorted_value, results_if.final_res, results_if.overflow);
			if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	// Result side: random stalls, or one long hold when asked.
	initial begin
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				results_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (gaps_on) begin
				results_if.ready <= ($urandom_range(0, 99) >= 20);
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: pick_value = {1'b1, {(DATA_W-1){1'b0}}};
			1: pick_value = {1'b0, {(DATA_W-1){1'b1}}};
			2, 3: pick_value = $signed(int'($urandom_range(0, 20)) - 10);
			default: pick_value = $urandom;
		endcase
	endfunction

	// Offer one value and hold it until the transaction completes.
	task automatic send_value(input logic signed [DATA_W-1:0] v, input logic last);
		if (gaps_on) begin
			while ($urandom_range(0, 99) < 20) begin
				items_if.valid <= 1'b0;
				@(posedge clk);
			end
		end
		items_if.valid   <= 1'b1;
		items_if.value   <= v;
		items_if.is_last <= last;
		@(posedge clk);
		while (!items_if.ready) @(posedge clk);
		values_offered++;
	endtask

	task automatic send_random_set(input int len);
		int i;
		for (i = 0; i < len; i++)
			send_value(pick_value(), i == len - 1);
	endtask

	task automatic stop_input();
		items_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_edge_values();
		// Extremes of both classes in one set.
		send_value(32'sh7FFF_FFFF, 1'b0);
		send_value(32'sh8000_0000, 1'b0);
		send_value(0, 1'b0);
		send_value(-1, 1'b0);
		send_value(1, 1'b0);
		send_value(-2, 1'b0);
		send_value(2, 1'b0);
		send_value(-3, 1'b1);
		// Single-value sets, one even and one odd.
		send_value(32'sh8000_0000, 1'b1);
		send_value(32'sh7FFF_FFFF, 1'b1);
		// Repeated values in both classes.
		send_value(5, 1'b0);
		send_value(-4, 1'b0);
		send_value(5, 1'b0);
		send_value(-4, 1'b0);
		send_value(5, 1'b1);
		// Evens only, then odds only.
		send_value(6, 1'b0);
		send_value(-8, 1'b0);
		send_value(0, 1'b1);
		send_value(-7, 1'b0);
		send_value(3, 1'b0);
		send_value(-1, 1'b1);
		stop_input();
	endtask

	task automatic test_full_store();
		// Exactly full, then closing value dropped, then several trailing drops.
		send_random_set(CAPACITY);
		send_random_set(CAPACITY + 1);
		send_random_set(CAPACITY + 3);
		stop_input();
	endtask

	task automatic test_full_rate();
		gaps_on = 1'b0;
		while (values_offered < 300)
			send_random_set($urandom_range(1, 6));
		stop_input();
		gaps_on = 1'b1;
	endtask

	task automatic test_output_hold();
		// Hold results off so the second set backs up at the input.
		hold_req = 1'b1;
		send_random_set(5);
		send_random_set(5);
		stop_input();
	endtask

	task automatic test_random_sets();
		while (values_offered < TARGET_VALS) begin
			if ($urandom_range(0, 19) == 0)
				send_random_set($urandom_range(20, 30));
			else
				send_random_set($urandom_range(1, 10));
		end
		stop_input();
	endtask

	initial begin
		arst_n           = 1'b0;
		items_if.valid   = 1'b0;
		items_if.value   = '0;
		items_if.is_last = 1'b0;
		set_fill         = 0;
		set_dropped      = 1'b0;
		mismatches       = 0;
		values_loaded    = 0;
		values_offered   = 0;
		sets_closed      = 0;
		sets_overflowed  = 0;
		words_checked    = 0;
		quiet_cycles     = 0;
		gaps_on          = 1'b1;
		hold_req         = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_edge_values();
		test_full_store();
		test_full_rate();
		test_output_hold();
		test_random_sets();

		while (pending_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Loaded %0d values in %0d sets, %0d of them over capacity.",
			values_loaded, sets_closed, sets_overflowed);
		$display("Checked %0d sorted words, with random stalls and one long output hold.",
			words_checked);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

[even_odd_split_sorter.f]
hw/rtl/eos_pkg.sv
hw/rtl/eos_in_if.sv
hw/rtl/eos_out_if.sv
hw/rtl/eos_ram.sv
hw/rtl/eos_datapath.sv
hw/rtl/eos_ctrl.sv
hw/rtl/even_odd_split_sorter.sv
test/even_odd_split_sorter_tb.sv
